[hdl/exi_pkg.sv]
// Shared types, constants and helper functions of the external bus controller.
`default_nettype none

package exi_pkg;

  // Register map of one channel
  localparam logic [5:0] CHAN_STRIDE   = 6'd20;
  localparam logic [5:0] LAST_OFFSET   = 6'h3C;
  localparam int unsigned REGS_PER_CHAN = 5;

  localparam logic [2:0] REG_STATUS   = 3'd0;
  localparam logic [2:0] REG_DMA_ADDR = 3'd1;
  localparam logic [2:0] REG_DMA_LEN  = 3'd2;
  localparam logic [2:0] REG_CONTROL  = 3'd3;
  localparam logic [2:0] REG_DATA     = 3'd4;

  // Status bits
  localparam logic [31:0] STAT_W1C       = 32'h0000_080A;
  localparam logic [31:0] STAT_KEEP      = 32'h0000_1000;
  localparam logic [31:0] STAT_IRQ_CLR   = 32'h0000_000A;
  localparam logic [31:0] STAT_DONE      = 32'h0000_0008;
  localparam logic [31:0] STAT_DONE_MASK = 32'h0000_0004;

  // Control fields
  localparam logic [31:0] CTRL_START = 32'h0000_0001;
  localparam logic [1:0]  DIR_WRITE  = 2'd1;

  // Chip commands
  localparam logic [31:0] CMD_MASK = 32'h7FFF_FF00;
  localparam logic [31:0] CMD_RTC  = 32'h2000_0000;
  localparam logic [31:0] CMD_SRAM = 32'h2000_0100;

  // Power-on image of the backup SRAM: checksum in bytes 0..3, flag byte
  localparam logic [31:0] SRAM_CSUM     = 32'h0040_FFB8;
  localparam logic [7:0]  SRAM_FLAG_IDX = 8'd19;
  localparam logic [7:0]  SRAM_FLAG     = 8'h40;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_STAT_WAIT,
    ST_XF_STAT,
    ST_XF_DATA,
    ST_BYTE,
    ST_BYTE_WAIT,
    ST_XF_DATA_WB,
    ST_XF_STAT_WB,
    ST_RESP
  } exi_state_e;

  // Power-on value of one SRAM byte
  function automatic logic [7:0] sram_reset_byte(input logic [7:0] idx);
    logic [7:0] b;
    case (idx)
      8'd0:          b = SRAM_CSUM[31:24];
      8'd1:          b = SRAM_CSUM[23:16];
      8'd2:          b = SRAM_CSUM[15:8];
      8'd3:          b = SRAM_CSUM[7:0];
      SRAM_FLAG_IDX: b = SRAM_FLAG;
      default:       b = 8'h00;
    endcase
    return b;
  endfunction

  // Flat register file index of a channel register: ch * 5 + reg
  function automatic logic [4:0] chan_reg_index(input logic [1:0] ch, input logic [2:0] ridx);
    return {1'b0, ch, 2'b00} + {3'b000, ch} + {2'b00, ridx};
  endfunction

endpackage

`default_nettype wire

[hdl/exi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module exi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/exi_bus_controller_with_rtc_sram.sv]
// External bus controller: three channels, RTC/SRAM chip on channel 0 device 1.
// A plain register write goes straight to the result; a read or status write first reads the
// register. A start reads status and data, moves any bytes, then writes back data on a read
// and the status; when the chip reads SRAM each byte takes a memory read and a wait step.
// One word at a time; the next is taken while the result waits, and a stalled result holds it.
// Reset clears control state, chip state and valid bits; the SRAM power-on image shows through per-byte valid bits.
`default_nettype none

module exi_bus_controller_with_rtc_sram
  import exi_pkg::*;
#(
  parameter int unsigned SRAM_BYTES   = 64,
  parameter int unsigned NUM_CHANNELS = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [5:0]  reg_offset_i,
  input  logic [31:0] write_data_i,
  input  logic [31:0] rtc_seconds_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic        irq_level_o
);

  localparam int unsigned RF_DEPTH = NUM_CHANNELS * REGS_PER_CHAN;
  localparam int unsigned RF_AW    = $clog2(RF_DEPTH);
  localparam int unsigned SA_W     = $clog2(SRAM_BYTES);

  exi_state_e state_q, state_d;

  // Item and transfer registers
  logic [1:0]  ch_q, ch_d;
  logic [31:0] wdata_q, wdata_d;
  logic [31:0] rtc_q, rtc_d;
  logic [31:0] rd_q, rd_d;
  logic [31:0] stat_q, stat_d;
  logic [31:0] data_q, data_d;
  logic [31:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        inrng_q, inrng_d;

  // Chip and interrupt state
  logic [31:0] cmd_q, cmd_d;
  logic [31:0] pos_q, pos_d;
  logic        irq_q, irq_d;

  // Output register
  logic        out_valid_q, out_valid_d;
  logic [31:0] read_data_q, read_data_d;
  logic        irq_level_q, irq_level_d;

  // Memory ports and valid bits
  logic                rf_we;
  logic [RF_AW-1:0]    rf_waddr, rf_raddr;
  logic [31:0]         rf_wdata, rf_rdata;
  logic                sr_we;
  logic [SA_W-1:0]     sr_waddr, sr_raddr;
  logic [7:0]          sr_wdata, sr_rdata;
  logic [RF_DEPTH-1:0] rf_vld_q;
  logic [SRAM_BYTES-1:0] sr_vld_q;
  logic                rf_rvld_q;
  logic                sr_rvld_q;
  logic [7:0]          sr_rst_q;

  // Decode of the incoming word
  logic [1:0]  dec_ch;
  logic [4:0]  dec_reg;
  logic [2:0]  dec_ridx;
  logic        dec_mapped;
  logic        dec_start;
  logic [RF_AW-1:0] dec_addr;

  // Transfer helpers
  logic [31:0] rf_old;
  logic [31:0] cmd_m;
  logic        chip;
  logic        rd_dir;
  logic        last;
  logic        pos_inrng;
  logic [4:0]  byte_sh;
  logic [7:0]  byte_in;
  logic [31:0] stat_new;
  logic [31:0] w1c_clr;

  exi_ram #(
    .WIDTH(32),
    .DEPTH(RF_DEPTH)
  ) u_regfile (
    .clk_i  (clk_i),
    .we_i   (rf_we),
    .waddr_i(rf_waddr),
    .wdata_i(rf_wdata),
    .raddr_i(rf_raddr),
    .rdata_o(rf_rdata)
  );

  exi_ram #(
    .WIDTH(8),
    .DEPTH(SRAM_BYTES)
  ) u_sram (
    .clk_i  (clk_i),
    .we_i   (sr_we),
    .waddr_i(sr_waddr),
    .wdata_i(sr_wdata),
    .raddr_i(sr_raddr),
    .rdata_o(sr_rdata)
  );

  // Split the offset into channel and register
  always_comb begin
    if (reg_offset_i < CHAN_STRIDE) begin
      dec_ch  = 2'd0;
      dec_reg = reg_offset_i[4:0];
    end else if (reg_offset_i < 6'(2 * CHAN_STRIDE)) begin
      dec_ch  = 2'd1;
      dec_reg = 5'(reg_offset_i - CHAN_STRIDE);
    end else if (reg_offset_i < 6'(3 * CHAN_STRIDE)) begin
      dec_ch  = 2'd2;
      dec_reg = 5'(reg_offset_i - 6'(2 * CHAN_STRIDE));
    end else begin
      dec_ch  = 2'd3;
      dec_reg = 5'(reg_offset_i - 6'(3 * CHAN_STRIDE));
    end
    dec_ridx   = dec_reg[4:2];
    dec_mapped = (reg_offset_i <= LAST_OFFSET) && (32'(dec_ch) < NUM_CHANNELS) &&
                 (dec_reg[1:0] == 2'b00);
    dec_start  = (write_data_i & CTRL_START) != 32'd0;
    dec_addr   = RF_AW'(chan_reg_index(dec_ch, dec_ridx));
  end

  // Transfer helpers
  assign rf_old    = rf_rvld_q ? rf_rdata : 32'd0;
  assign cmd_m     = cmd_q & CMD_MASK;
  assign chip      = (ch_q == 2'd0) && !stat_q[7] && stat_q[8];
  assign rd_dir    = wdata_q[3:2] != DIR_WRITE;
  assign last      = cnt_q == wdata_q[5:4];
  assign pos_inrng = pos_q < 32'(SRAM_BYTES);
  assign byte_sh   = {~cnt_q, 3'b000};
  assign w1c_clr   = wdata_q & STAT_W1C;
  assign stat_new  = (rf_old & STAT_KEEP) | (rf_old & STAT_W1C & ~w1c_clr) |
                     (wdata_q & ~STAT_W1C & ~STAT_KEEP);
  assign byte_in   = inrng_q ? (sr_rvld_q ? sr_rdata : sr_rst_q) : 8'h00;

  assign in_ready_o = state_q == ST_IDLE;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (!dec_mapped) begin
            state_d = ST_RESP;
          end else if (!mode_i) begin
            state_d = ST_RD_WAIT;
          end else if (dec_ridx == REG_STATUS) begin
            state_d = ST_STAT_WAIT;
          end else if (dec_ridx == REG_CONTROL && dec_start) begin
            state_d = ST_XF_STAT;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_RD_WAIT:   state_d = ST_RESP;
      ST_STAT_WAIT: state_d = ST_RESP;
      ST_XF_STAT:   state_d = ST_XF_DATA;
      ST_XF_DATA: begin
        if (wdata_q[1]) begin
          state_d = ST_XF_STAT_WB;
        end else if (!rd_dir) begin
          state_d = (chip && wdata_q[5:4] != 2'd3) ? ST_BYTE : ST_XF_STAT_WB;
        end else begin
          state_d = ST_BYTE;
        end
      end
      ST_BYTE: begin
        if (rd_dir && chip && cmd_m == CMD_SRAM) begin
          state_d = ST_BYTE_WAIT;
        end else if (last) begin
          state_d = rd_dir ? ST_XF_DATA_WB : ST_XF_STAT_WB;
        end
      end
      ST_BYTE_WAIT:  state_d = last ? ST_XF_DATA_WB : ST_BYTE;
      ST_XF_DATA_WB: state_d = ST_XF_STAT_WB;
      ST_XF_STAT_WB: state_d = ST_RESP;
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath, memory controls and outputs
  always_comb begin
    ch_d        = ch_q;
    wdata_d     = wdata_q;
    rtc_d       = rtc_q;
    rd_d        = rd_q;
    stat_d      = stat_q;
    data_d      = data_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    inrng_d     = inrng_q;
    cmd_d       = cmd_q;
    pos_d       = pos_q;
    irq_d       = irq_q;
    read_data_d = read_data_q;
    irq_level_d = irq_level_q;
    rf_we       = 1'b0;
    rf_waddr    = '0;
    rf_wdata    = 32'd0;
    rf_raddr    = '0;
    sr_we       = 1'b0;
    sr_waddr    = '0;
    sr_wdata    = 8'h00;
    sr_raddr    = '0;

    // Drop the result word once it is taken
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ch_d    = dec_ch;
          wdata_d = write_data_i;
          rtc_d   = rtc_seconds_i;
          rd_d    = 32'd0;
          if (dec_mapped) begin
            if (!mode_i || dec_ridx == REG_STATUS) begin
              rf_raddr = dec_addr;
            end else begin
              rf_we    = 1'b1;
              rf_waddr = dec_addr;
              rf_wdata = write_data_i;
              if (dec_ridx == REG_CONTROL) begin
                // Start bit never survives: the transfer completes before the next word is taken
                rf_wdata = write_data_i & ~CTRL_START;
                rf_raddr = RF_AW'(chan_reg_index(dec_ch, REG_STATUS));
              end
            end
          end
        end
      end
      ST_RD_WAIT: begin
        rd_d = rf_old;
      end
      ST_STAT_WAIT: begin
        rf_we    = 1'b1;
        rf_waddr = RF_AW'(chan_reg_index(ch_q, REG_STATUS));
        rf_wdata = stat_new;
        if ((w1c_clr & STAT_IRQ_CLR) != 32'd0) begin
          irq_d = 1'b0;
        end
      end
      ST_XF_STAT: begin
        stat_d   = rf_old;
        acc_d    = 32'd0;
        cnt_d    = 2'd0;
        rf_raddr = RF_AW'(chan_reg_index(ch_q, REG_DATA));
      end
      ST_XF_DATA: begin
        data_d = rf_old;
        // Four-byte chip write loads the command word
        if (!wdata_q[1] && !rd_dir && chip && wdata_q[5:4] == 2'd3) begin
          cmd_d = rf_old;
          pos_d = 32'd0;
        end
      end
      ST_BYTE: begin
        if (!rd_dir) begin
          if (cmd_m == CMD_SRAM && pos_inrng) begin
            sr_we    = 1'b1;
            sr_waddr = pos_q[SA_W-1:0];
            sr_wdata = 8'(data_q >> byte_sh);
          end
          pos_d = pos_q + 32'd1;
          cnt_d = cnt_q + 2'd1;
        end else if (!chip) begin
          acc_d = acc_q | (32'h0000_00FF << byte_sh);
          cnt_d = cnt_q + 2'd1;
        end else if (cmd_m == CMD_SRAM) begin
          // Fetch the byte; it is placed in the wait step
          inrng_d = pos_inrng;
          if (pos_inrng) begin
            sr_raddr = pos_q[SA_W-1:0];
          end
        end else begin
          if (cmd_m == CMD_RTC) begin
            acc_d = acc_q | (32'(8'(rtc_q >> {~pos_q[1:0], 3'b000})) << byte_sh);
          end
          pos_d = pos_q + 32'd1;
          cnt_d = cnt_q + 2'd1;
        end
      end
      ST_BYTE_WAIT: begin
        acc_d = acc_q | (32'(byte_in) << byte_sh);
        pos_d = pos_q + 32'd1;
        cnt_d = cnt_q + 2'd1;
      end
      ST_XF_DATA_WB: begin
        rf_we    = 1'b1;
        rf_waddr = RF_AW'(chan_reg_index(ch_q, REG_DATA));
        rf_wdata = acc_q;
      end
      ST_XF_STAT_WB: begin
        rf_we    = 1'b1;
        rf_waddr = RF_AW'(chan_reg_index(ch_q, REG_STATUS));
        rf_wdata = stat_q | STAT_DONE;
        if ((stat_q & STAT_DONE_MASK) != 32'd0) begin
          irq_d = 1'b1;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          read_data_d = rd_q;
          irq_level_d = irq_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state, chip state and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      irq_q       <= 1'b0;
      cmd_q       <= 32'd0;
      pos_q       <= 32'd0;
      rf_vld_q    <= '0;
      sr_vld_q    <= '0;
      rf_rvld_q   <= 1'b0;
      sr_rvld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      irq_q       <= irq_d;
      cmd_q       <= cmd_d;
      pos_q       <= pos_d;
      if (rf_we) begin
        rf_vld_q[rf_waddr] <= 1'b1;
      end
      if (sr_we) begin
        sr_vld_q[sr_waddr] <= 1'b1;
      end
      rf_rvld_q <= rf_vld_q[rf_raddr];
      sr_rvld_q <= sr_vld_q[sr_raddr];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ch_q        <= ch_d;
    wdata_q     <= wdata_d;
    rtc_q       <= rtc_d;
    rd_q        <= rd_d;
    stat_q      <= stat_d;
    data_q      <= data_d;
    acc_q       <= acc_d;
    cnt_q       <= cnt_d;
    inrng_q     <= inrng_d;
    read_data_q <= read_data_d;
    irq_level_q <= irq_level_d;
    sr_rst_q    <= sram_reset_byte(8'(sr_raddr));
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign irq_level_o = irq_level_q;

endmodule

`default_nettype wire
